### rtl/core/crcdf_pkg.sv
// Shared types, constants and the CRC-32 byte step for the frame deframer.
// No dependencies; the CRC unit, the top level and the test import this package.
package crcdf_pkg;

   localparam logic [7:0]  MAGIC_BYTE = 8'h4D;
   localparam int unsigned HDR_LEN    = 7;
   localparam int unsigned TRL_LEN    = 4;
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

   localparam logic CMD_FEED = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic REG_EXPECTED_VERSION = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_CRC,
      ST_EVAL,
      ST_SCAN,
      ST_COPY,
      ST_POST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic init;
      logic step;
   } crc_ctl_type;

   // One byte through the reflected CRC-32 register.
   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] d);
      logic [31:0] c;
      c = c_in ^ {24'd0, d};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### rtl/core/crcdf_buf.sv
// Frame byte buffer: one write port, one registered read port.
// Depends on nothing beyond its parameters.
module crcdf_buf #(
   parameter int unsigned DEPTH = 2048,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/crcdf_crc.sv
// CRC-32 accumulator, one byte per step, shared by every frame check.
// Depends on crcdf_pkg.
module crcdf_crc (
   input  logic                 clock,
   input  crcdf_pkg::crc_ctl_type ctl,
   input  logic [7:0]           data,
   output logic [31:0]          crc
);
   import crcdf_pkg::*;

   logic [31:0] crc_ff;
   logic [31:0] crc_in;

   // Preset or advance by one byte
   always_comb begin
      crc_in = crc_ff;
      if (ctl.init) begin
         crc_in = CRC_PRESET;
      end else if (ctl.step) begin
         crc_in = crc_byte(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = ~crc_ff;

endmodule

### rtl/core/crc32_frame_deframer_resync_top.sv
// Channel | Dir | Fields (low bit first)
// req     | in  | tuser: command; tdata: stream_byte, read_index
// rsp     | out | tuser: frame_ready; tdata: frame_type, frame_seq, payload_length,
//         |     |        read_data, good_frames, version_drops, oversize_drops,
//         |     |        crc_drops, resync_count
// csr     | cfg | APB write/read of expected_version at byte address 0
// A read of an index at or past the stored length skips the buffer and returns zero.
// A frame check reads header, payload and trailer on the one buffer read port.
// A resync scans up to the next magic and copies the kept bytes down, one byte a
// cycle each.
// The input is not ready while an item is at work; a stalled result holds in its
// register and the next item is taken once the result register is loaded.
// Synchronous active-high reset clears all counters and the fill state.
// Depends on crcdf_pkg, crcdf_buf, crcdf_crc.
module crc32_frame_deframer_resync_top #(
   parameter int unsigned MAX_PAYLOAD  = 1024,
   parameter int unsigned BUFFER_BYTES = 2048
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [0:0]   req_tuser,   // [0] command
   input  logic [23:0]  req_tdata,   // [7:0] stream_byte, [17:8] read_index
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [0:0]   rsp_tuser,   // [0] frame_ready
   output logic [199:0] rsp_tdata,   // [7:0] type, [15:8] seq, [26:16] length,
                                     // [34:27] read_data, [66:35] good_frames,
                                     // [98:67] version_drops, [130:99] oversize_drops,
                                     // [162:131] crc_drops, [194:163] resync_count
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import crcdf_pkg::*;

   localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
   localparam int unsigned CNT_W  = $clog2(BUFFER_BYTES + 1);
   localparam int unsigned EXP_W  = $clog2(MAX_PAYLOAD + 12);
   localparam int unsigned LL_W   = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned CMP_W  = (CNT_W > EXP_W) ? CNT_W : EXP_W;
   localparam int unsigned IW     = (LL_W > 10) ? LL_W : 10;
   localparam int unsigned PW     = (CNT_W > 11) ? CNT_W : 11;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [EXP_W-1:0] exp_ff, exp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] src_ff, src_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0] rd_k_ff, rd_k_in;
   logic             rd_v_ff, rd_v_in;
   logic             prev_m_ff, prev_m_in;
   logic             pend_ff, pend_in;
   logic [7:0]       pbyte_ff, pbyte_in;
   logic [31:0]      want_ff, want_in;
   logic             flag_ff, flag_in;
   logic [7:0]       rdat_ff, rdat_in;
   logic [7:0]       ver_b_ff, ver_b_in, typ_b_ff, typ_b_in, seq_b_ff, seq_b_in;
   logic [7:0]       lenl_b_ff, lenl_b_in, lenh_b_ff, lenh_b_in;
   logic [7:0]       last_type_ff, last_type_in, last_seq_ff, last_seq_in;
   logic [LL_W-1:0]  last_len_ff, last_len_in;
   logic [31:0]      fcnt_ff, fcnt_in, vcnt_ff, vcnt_in, ocnt_ff, ocnt_in;
   logic [31:0]      ccnt_ff, ccnt_in, rcnt_ff, rcnt_in;
   logic [7:0]       expv_ff, expv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_flag_ff, rsp_flag_in;
   logic [199:0]     rsp_data_ff, rsp_data_in;

   // Buffer and CRC unit controls
   logic             wr_en, rd_en;
   logic [CNT_W-1:0] wr_idx, rd_idx;
   logic [7:0]       wr_byte, buf_rd;
   crc_ctl_type      crc_ctl;
   logic [31:0]      crc_val;

   crcdf_buf #(.DEPTH(BUFFER_BYTES), .ADDR_W(ADDR_W)) u_buf (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx[ADDR_W-1:0]),
      .wr_data(wr_byte),
      .rd_en  (rd_en),
      .rd_addr(rd_idx[ADDR_W-1:0]),
      .rd_data(buf_rd)
   );

   crcdf_crc u_crc (
      .clock(clock),
      .ctl  (crc_ctl),
      .data (buf_rd),
      .crc  (crc_val)
   );

   // Input fields and handshake
   logic       req_fire, cmd;
   logic [7:0] in_byte;
   logic [9:0] in_idx;
   assign cmd        = req_tuser[0];
   assign in_byte    = req_tdata[7:0];
   assign in_idx     = req_tdata[17:8];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Shared decisions
   logic [15:0]      len16;
   logic             fill_lt2, fill_zero, fill_one, fill_full;
   logic             hdr_need, ver_bad, len_bad, crc_go;
   logic [EXP_W-1:0] exp_eff;
   logic             is_m, scan_pair, scan_last, scan_hit, scan_end;
   logic             copy_last, crc_last, crc_ok, out_free;
   logic [PW-1:0]    rd_pos;
   logic             read_ok;

   assign len16     = {lenh_b_ff, lenl_b_ff};
   assign fill_zero = (fill_ff == '0);
   assign fill_one  = (fill_ff == CNT_W'(1));
   assign fill_lt2  = (fill_ff < CNT_W'(2));
   assign fill_full = (fill_ff >= CNT_W'(BUFFER_BYTES));
   assign hdr_need  = (exp_ff == '0) && (fill_ff >= CNT_W'(HDR_LEN));
   assign ver_bad   = hdr_need && (ver_b_ff != expv_ff);
   assign len_bad   = hdr_need && !ver_bad && (len16 > 16'(MAX_PAYLOAD));
   assign exp_eff   = hdr_need ? (EXP_W'(len16) + EXP_W'(HDR_LEN + TRL_LEN)) : exp_ff;
   assign crc_go    = (exp_eff != '0) && (CMP_W'(fill_ff) >= CMP_W'(exp_eff));
   assign is_m      = (buf_rd == MAGIC_BYTE);
   assign scan_pair = rd_v_ff && (rd_k_ff >= CNT_W'(2)) && prev_m_ff && is_m;
   assign scan_last = rd_v_ff && (rd_k_ff == fill_ff - CNT_W'(1));
   assign scan_hit  = scan_pair || (scan_last && is_m);
   assign scan_end  = scan_hit || scan_last || fill_lt2;
   assign copy_last = rd_v_ff && (rd_k_ff == keep_ff - CNT_W'(1));
   assign crc_last  = rd_v_ff && (CMP_W'(rd_k_ff) == CMP_W'(exp_ff - EXP_W'(1)));
   assign crc_ok    = (crc_val == want_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign rd_pos    = PW'(in_idx) + PW'(HDR_LEN);
   assign read_ok   = (IW'(in_idx) < IW'(last_len_ff)) && (rd_pos < PW'(BUFFER_BYTES));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (cmd == CMD_READ) begin
                  state_in = read_ok ? ST_READ : ST_DONE;
               end else if (fill_zero || fill_one) begin
                  state_in = ST_DONE;
               end else if (fill_full) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_CHECK: begin
            priority if (fill_lt2)           state_in = ST_DONE;
            else if (ver_bad || len_bad)     state_in = ST_SCAN;
            else if (crc_go)                 state_in = ST_CRC;
            else                             state_in = ST_DONE;
         end
         ST_CRC: if (crc_last) state_in = ST_EVAL;
         ST_EVAL: state_in = crc_ok ? ST_DONE : ST_SCAN;
         ST_SCAN: begin
            priority if (scan_hit) state_in = ST_COPY;
            else if (scan_end)     state_in = ST_POST;
         end
         ST_COPY: if (copy_last) state_in = ST_POST;
         ST_POST: state_in = ST_CHECK;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and unit controls
   always_comb begin
      fill_in = fill_ff;       exp_in = exp_ff;       cnt_in = cnt_ff;
      src_in = src_ff;         keep_in = keep_ff;     rd_k_in = rd_k_ff;
      rd_v_in = 1'b0;          prev_m_in = prev_m_ff; pend_in = pend_ff;
      pbyte_in = pbyte_ff;     want_in = want_ff;     flag_in = flag_ff;
      rdat_in = rdat_ff;
      last_type_in = last_type_ff; last_seq_in = last_seq_ff; last_len_in = last_len_ff;
      fcnt_in = fcnt_ff; vcnt_in = vcnt_ff; ocnt_in = ocnt_ff;
      ccnt_in = ccnt_ff; rcnt_in = rcnt_ff;
      rsp_valid_in = rsp_valid_ff; rsp_flag_in = rsp_flag_ff; rsp_data_in = rsp_data_ff;
      wr_en = 1'b0; wr_idx = fill_ff; wr_byte = in_byte;
      rd_en = 1'b0; rd_idx = cnt_ff;
      crc_ctl = '0;

      // Drain the result register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               flag_in = 1'b0;
               rdat_in = 8'd0;
               if (cmd == CMD_READ) begin
                  rd_en  = read_ok;
                  rd_idx = CNT_W'(rd_pos);
               end else if (fill_zero) begin
                  if (in_byte == MAGIC_BYTE) begin
                     wr_en   = 1'b1;
                     fill_in = CNT_W'(1);
                  end
               end else if (fill_one) begin
                  if (in_byte == MAGIC_BYTE) begin
                     wr_en   = 1'b1;
                     fill_in = CNT_W'(2);
                  end else begin
                     fill_in = '0;
                  end
               end else if (fill_full) begin
                  // Resync first, then store the byte
                  pend_in   = 1'b1;
                  pbyte_in  = in_byte;
                  rcnt_in   = rcnt_ff + 32'd1;
                  cnt_in    = CNT_W'(1);
                  prev_m_in = 1'b0;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end
         ST_READ: rdat_in = buf_rd;
         ST_CHECK: begin
            if (!fill_lt2) begin
               if (ver_bad || len_bad) begin
                  if (ver_bad) vcnt_in = vcnt_ff + 32'd1;
                  else         ocnt_in = ocnt_ff + 32'd1;
                  rcnt_in   = rcnt_ff + 32'd1;
                  cnt_in    = CNT_W'(1);
                  prev_m_in = 1'b0;
               end else begin
                  exp_in = exp_eff;
                  if (crc_go) begin
                     cnt_in       = '0;
                     crc_ctl.init = 1'b1;
                  end
               end
            end
         end
         ST_CRC: begin
            // Issue one read a cycle over header, payload and trailer
            if (!crc_last && (CMP_W'(cnt_ff) < CMP_W'(exp_ff))) begin
               rd_en   = 1'b1;
               rd_idx  = cnt_ff;
               cnt_in  = cnt_ff + CNT_W'(1);
               rd_v_in = 1'b1;
               rd_k_in = cnt_ff;
            end
            if (rd_v_ff) begin
               if (CMP_W'(rd_k_ff) < CMP_W'(exp_ff - EXP_W'(TRL_LEN))) begin
                  crc_ctl.step = 1'b1;
               end else begin
                  want_in = {buf_rd, want_ff[31:8]};
               end
            end
         end
         ST_EVAL: begin
            if (crc_ok) begin
               last_type_in = typ_b_ff;
               last_seq_in  = seq_b_ff;
               last_len_in  = LL_W'(exp_ff - EXP_W'(HDR_LEN + TRL_LEN));
               fcnt_in      = fcnt_ff + 32'd1;
               fill_in      = '0;
               exp_in       = '0;
               flag_in      = 1'b1;
            end else begin
               ccnt_in   = ccnt_ff + 32'd1;
               rcnt_in   = rcnt_ff + 32'd1;
               cnt_in    = CNT_W'(1);
               prev_m_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // Look for the next magic pair, or a lone trailing magic
            if (!scan_end && (cnt_ff < fill_ff)) begin
               rd_en   = 1'b1;
               rd_idx  = cnt_ff;
               cnt_in  = cnt_ff + CNT_W'(1);
               rd_v_in = 1'b1;
               rd_k_in = cnt_ff;
            end
            if (rd_v_ff) begin
               prev_m_in = is_m;
            end
            if (scan_hit) begin
               src_in  = scan_pair ? (rd_k_ff - CNT_W'(1)) : rd_k_ff;
               keep_in = fill_ff - (scan_pair ? (rd_k_ff - CNT_W'(1)) : rd_k_ff);
               cnt_in  = '0;
            end else if (scan_end) begin
               fill_in = '0;
               exp_in  = '0;
            end
         end
         ST_COPY: begin
            // Move the kept bytes down to the start of the buffer
            if (!copy_last && (cnt_ff < keep_ff)) begin
               rd_en   = 1'b1;
               rd_idx  = src_ff + cnt_ff;
               cnt_in  = cnt_ff + CNT_W'(1);
               rd_v_in = 1'b1;
               rd_k_in = cnt_ff;
            end
            if (rd_v_ff) begin
               wr_en   = 1'b1;
               wr_idx  = rd_k_ff;
               wr_byte = buf_rd;
            end
            if (copy_last) begin
               fill_in = keep_ff;
               exp_in  = '0;
            end
         end
         ST_POST: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_byte = pbyte_ff;
               fill_in = fill_ff + CNT_W'(1);
               pend_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = flag_ff;
               rsp_data_in  = {5'd0, rcnt_ff, ccnt_ff, ocnt_ff, vcnt_ff, fcnt_ff,
                               rdat_ff, 11'(last_len_ff), last_seq_ff, last_type_ff};
            end
         end
         default: ;
      endcase
   end

   // Shadow header bytes as they are written
   always_comb begin
      ver_b_in = ver_b_ff; typ_b_in = typ_b_ff; seq_b_in = seq_b_ff;
      lenl_b_in = lenl_b_ff; lenh_b_in = lenh_b_ff;
      if (wr_en) begin
         if (wr_idx == CNT_W'(2)) ver_b_in  = wr_byte;
         if (wr_idx == CNT_W'(3)) typ_b_in  = wr_byte;
         if (wr_idx == CNT_W'(4)) seq_b_in  = wr_byte;
         if (wr_idx == CNT_W'(5)) lenl_b_in = wr_byte;
         if (wr_idx == CNT_W'(6)) lenh_b_in = wr_byte;
      end
   end

   // Configuration write and read
   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_EXPECTED_VERSION) ? {24'd0, expv_ff} : 32'd0;

   always_comb begin
      expv_in = expv_ff;
      if (csr_wr && (csr_paddr[2] == REG_EXPECTED_VERSION)) begin
         expv_in = csr_pwdata[7:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         exp_ff       <= '0;
         rd_v_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         last_type_ff <= '0;
         last_seq_ff  <= '0;
         last_len_ff  <= '0;
         fcnt_ff      <= '0;
         vcnt_ff      <= '0;
         ocnt_ff      <= '0;
         ccnt_ff      <= '0;
         rcnt_ff      <= '0;
         expv_ff      <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         exp_ff       <= exp_in;
         rd_v_ff      <= rd_v_in;
         pend_ff      <= pend_in;
         last_type_ff <= last_type_in;
         last_seq_ff  <= last_seq_in;
         last_len_ff  <= last_len_in;
         fcnt_ff      <= fcnt_in;
         vcnt_ff      <= vcnt_in;
         ocnt_ff      <= ocnt_in;
         ccnt_ff      <= ccnt_in;
         rcnt_ff      <= rcnt_in;
         expv_ff      <= expv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      src_ff      <= src_in;
      keep_ff     <= keep_in;
      rd_k_ff     <= rd_k_in;
      prev_m_ff   <= prev_m_in;
      pbyte_ff    <= pbyte_in;
      want_ff     <= want_in;
      flag_ff     <= flag_in;
      rdat_ff     <= rdat_in;
      ver_b_ff    <= ver_b_in;
      typ_b_ff    <= typ_b_in;
      seq_b_ff    <= seq_b_in;
      lenl_b_ff   <= lenl_b_in;
      lenh_b_ff   <= lenh_b_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_flag_ff;
   assign rsp_tdata    = rsp_data_ff;

endmodule

### rtl/core/crcdf_check.sv
// Port-level checks for the frame deframer, bound to the top level.
// Depends on crc32_frame_deframer_resync_top.
module crcdf_check (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [0:0]   rsp_tuser,
   input logic [199:0] rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Not ready in the cycle after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // A completed frame shows a nonzero frame count
   a_ready_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[66:35] != 32'd0)
      else $error("frame_ready with zero frame count");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind crc32_frame_deframer_resync_top crcdf_check u_crcdf_check (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tuser (rsp_tuser),
   .rsp_tdata (rsp_tdata)
);

### sim/crc32_frame_deframer_resync_top_test.sv
// Self-checking test of the magic/length/CRC-32 frame deframer with resync.
// Predicts every result item from a local copy of the deframer state; needs crcdf_pkg.
module crc32_frame_deframer_resync_top_test;
   import crcdf_pkg::*;

   localparam int unsigned PAYLOAD_MAX  = 1024;
   localparam int unsigned BUF_DEPTH    = 2048;
   localparam int unsigned CYCLE_LIMIT  = 4000000;
   localparam int unsigned RANDOM_ITEMS = 570;
   localparam logic [2:0]  ADDR_VERSION = 3'(REG_EXPECTED_VERSION) << 2;

   typedef logic [7:0] byte_q_type[$];

   typedef struct {
      logic        ready;
      logic [7:0]  ftype;
      logic [7:0]  fseq;
      logic [10:0] flen;
      logic [7:0]  rdata;
      logic [31:0] good;
      logic [31:0] vdrop;
      logic [31:0] odrop;
      logic [31:0] cdrop;
      logic [31:0] rsync;
   } deframe_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [0:0]   req_tuser;   // [0] command
   logic [23:0]  req_tdata;   // [7:0] stream_byte, [17:8] read_index
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [0:0]   rsp_tuser;   // [0] frame_ready
   logic [199:0] rsp_tdata;   // type, seq, length, read_data, five counters
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // shadow deframer state
   logic [7:0]  shadow_buf [0:BUF_DEPTH-1];
   int unsigned fill;
   int unsigned frame_total;
   logic [7:0]  last_type;
   logic [7:0]  last_seq;
   logic [10:0] last_len;
   logic [31:0] cnt_good;
   logic [31:0] cnt_version;
   logic [31:0] cnt_oversize;
   logic [31:0] cnt_crc;
   logic [31:0] cnt_resync;
   logic [7:0]  version_sel;

   deframe_result_type pending_results[$];
   int unsigned     fail_count;
   int unsigned     items_sent;
   int unsigned     cycles;
   bit              no_idle;

   crc32_frame_deframer_resync_top u_dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, want, $time);
      fail_count++;
   endtask

   // Pick an idle length: mostly none or short, a few long.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Reflected CRC-32 over a byte list.
   function automatic logic [31:0] crc32_bytes(input byte_q_type data, input int unsigned n);
      logic [31:0] c;
      c = 32'hFFFFFFFF;
      for (int i = 0; i < n; i++) begin
         c ^= {24'd0, data[i]};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      return ~c;
   endfunction

   function automatic logic [31:0] shadow_crc(input int unsigned n);
      byte_q_type q;
      for (int i = 0; i < n; i++) q.push_back(shadow_buf[i]);
      return crc32_bytes(q, n);
   endfunction

   // Drop the first buffered byte and keep from the next magic pair or a lone trailing magic.
   function automatic void shadow_resync();
      int unsigned keep;
      keep = 0;
      cnt_resync++;
      for (int unsigned i = 1; i < fill; i++) begin
         if (shadow_buf[i] == MAGIC_BYTE && (i + 1 == fill || shadow_buf[i+1] == MAGIC_BYTE)) begin
            keep = fill - i;
            break;
         end
      end
      for (int unsigned j = 0; j < keep; j++) shadow_buf[j] = shadow_buf[fill - keep + j];
      fill = keep;
      frame_total = 0;
   endfunction

   function automatic bit shadow_feed(input logic [7:0] b);
      int unsigned flen;
      int unsigned body;
      logic [31:0] want;
      if (fill == 0) begin
         if (b == MAGIC_BYTE) begin
            shadow_buf[0] = b;
            fill = 1;
         end
         return 0;
      end
      if (fill == 1) begin
         if (b == MAGIC_BYTE) begin
            shadow_buf[1] = b;
            fill = 2;
         end else begin
            fill = 0;
         end
         return 0;
      end
      if (fill >= BUF_DEPTH) shadow_resync();
      shadow_buf[fill] = b;
      fill++;
      forever begin
         if (fill < 2) return 0;
         if (frame_total == 0 && fill >= HDR_LEN) begin
            flen = {shadow_buf[6], shadow_buf[5]};
            if (shadow_buf[2] != version_sel) begin
               cnt_version++;
               shadow_resync();
               continue;
            end
            if (flen > PAYLOAD_MAX) begin
               cnt_oversize++;
               shadow_resync();
               continue;
            end
            frame_total = HDR_LEN + TRL_LEN + flen;
         end
         if (frame_total != 0 && fill >= frame_total) begin
            body = frame_total - TRL_LEN;
            want = {shadow_buf[body+3], shadow_buf[body+2], shadow_buf[body+1], shadow_buf[body]};
            if (shadow_crc(body) != want) begin
               cnt_crc++;
               shadow_resync();
               continue;
            end
            last_type = shadow_buf[3];
            last_seq = shadow_buf[4];
            last_len = 11'(body - HDR_LEN);
            cnt_good++;
            fill = 0;
            frame_total = 0;
            return 1;
         end
         return 0;
      end
   endfunction

   function automatic deframe_result_type predict_item(input logic cmd, input logic [7:0] b,
                                                      input logic [9:0] idx);
      deframe_result_type r;
      r.ready = 1'b0;
      r.rdata = 8'd0;
      if (cmd == CMD_FEED) r.ready = shadow_feed(b);
      else if (idx < last_len && HDR_LEN + idx < BUF_DEPTH) r.rdata = shadow_buf[HDR_LEN + idx];
      r.ftype = last_type;
      r.fseq = last_seq;
      r.flen = last_len;
      r.good = cnt_good;
      r.vdrop = cnt_version;
      r.odrop = cnt_oversize;
      r.cdrop = cnt_crc;
      r.rsync = cnt_resync;
      return r;
   endfunction

   // Send one item after a random gap, record its expected result, then drop valid.
   task automatic send_item(input logic cmd, input logic [7:0] b, input logic [9:0] idx);
      int unsigned n;
      n = idle_len();
      repeat (n) @(negedge clock);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {6'd0, idx, b};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_item(cmd, b, idx));
      items_sent++;
      @(negedge clock) req_tvalid <= 1'b0;
   endtask

   task automatic feed(input logic [7:0] b);
      send_item(CMD_FEED, b, 10'($urandom));
   endtask

   task automatic read_payload(input logic [9:0] idx);
      send_item(CMD_READ, 8'($urandom), idx);
   endtask

   // Build and feed a frame; bad_crc flips one CRC bit.
   task automatic send_frame(input logic [7:0] ver, input logic [15:0] flen,
                             input bit bad_crc, input logic [7:0] ftype = 8'($urandom),
                             input logic [7:0] fseq = 8'($urandom));
      byte_q_type q;
      logic [31:0] c;
      int unsigned plen;
      q = '{MAGIC_BYTE, MAGIC_BYTE, ver, ftype, fseq, flen[7:0], flen[15:8]};
      plen = (flen > PAYLOAD_MAX) ? $urandom_range(0, 8) : flen;
      for (int i = 0; i < plen; i++) q.push_back(8'($urandom));
      c = crc32_bytes(q, q.size());
      if (bad_crc) c ^= 32'd1 << $urandom_range(0, 31);
      for (int i = 0; i < 4; i++) q.push_back(c[8*i +: 8]);
      foreach (q[i]) feed(q[i]);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write expected_version while idle, then read it back.
   task automatic write_version(input logic [7:0] v);
      wait_drained();
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_VERSION;
      csr_pwdata <= {24'($urandom), v};
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      version_sel = v;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[7:0] !== v) report_mismatch("expected_version readback", csr_prdata, v);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Compare each result item against the oldest prediction.
   always @(posedge clock) begin
      deframe_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result item", rsp_tdata[31:0], 0);
         end else begin
            e = pending_results.pop_front();
            if (rsp_tuser[0] !== e.ready) report_mismatch("frame_ready", rsp_tuser[0], e.ready);
            if (rsp_tdata[7:0] !== e.ftype) report_mismatch("frame_type", rsp_tdata[7:0], e.ftype);
            if (rsp_tdata[15:8] !== e.fseq) report_mismatch("frame_seq", rsp_tdata[15:8], e.fseq);
            if (rsp_tdata[26:16] !== e.flen)
               report_mismatch("payload_length", rsp_tdata[26:16], e.flen);
            if (rsp_tdata[34:27] !== e.rdata)
               report_mismatch("read_data", rsp_tdata[34:27], e.rdata);
            if (rsp_tdata[66:35] !== e.good)
               report_mismatch("good_frames", rsp_tdata[66:35], e.good);
            if (rsp_tdata[98:67] !== e.vdrop)
               report_mismatch("version_drops", rsp_tdata[98:67], e.vdrop);
            if (rsp_tdata[130:99] !== e.odrop)
               report_mismatch("oversize_drops", rsp_tdata[130:99], e.odrop);
            if (rsp_tdata[162:131] !== e.cdrop)
               report_mismatch("crc_drops", rsp_tdata[162:131], e.cdrop);
            if (rsp_tdata[194:163] !== e.rsync)
               report_mismatch("resync_count", rsp_tdata[194:163], e.rsync);
         end
      end
   end

   // Stall the result side at random.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (idle_len() == 0);
   end

   // Hunting, good, short and maximal frames, every drop reason, reads.
   task automatic test_directed();
      read_payload(10'd0);
      read_payload(10'd1023);
      feed(8'h00);
      feed(MAGIC_BYTE);
      feed(8'hFF);
      send_frame(8'd1, 16'd0, 0, 8'h00, 8'h00);
      send_frame(8'd1, 16'd3, 0, 8'hFF, 8'hFF);
      wait_drained();
      read_payload(10'd0);
      read_payload(10'd2);
      read_payload(10'd3);
      read_payload(10'd1023);
      send_frame(8'd7, 16'd4, 0);
      send_frame(8'd1, 16'd1025, 0);
      send_frame(8'd1, 16'hFFFF, 0);
      send_frame(8'd1, 16'd5, 1);
      // garbage with a trailing lone magic byte, then a frame behind it
      feed(8'h4D);
      feed(8'h4D);
      feed(8'h01);
      feed(8'h4D);
      send_frame(8'd1, 16'd2, 0);
      send_frame(8'd1, 16'(PAYLOAD_MAX), 0);
      read_payload(10'd1023);
      read_payload(10'd511);
   endtask

   // Walk through several version settings, extremes included.
   task automatic test_version_setting();
      logic [7:0] vals[4];
      vals = '{8'd0, 8'd255, 8'($urandom), 8'd1};
      foreach (vals[i]) begin
         write_version(vals[i]);
         send_frame(vals[i], 16'd6, 0);
         send_frame(vals[i] ^ 8'h80, 16'd2, 0);
         read_payload(10'd5);
      end
   endtask

   // Mostly well-formed frames with random content; some noise and broken frames.
   task automatic test_random_stream();
      int unsigned start;
      int unsigned r;
      int unsigned seg;
      start = items_sent;
      seg = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            send_frame(version_sel, 16'($urandom_range(0, 24)), 0);
         end else if (r < 66) begin
            send_frame(version_sel, 16'($urandom_range(0, 24)), 1);
         end else if (r < 70) begin
            send_frame(8'($urandom), 16'($urandom_range(0, 24)), 0);
         end else if (r < 73) begin
            send_frame(version_sel, 16'($urandom_range(PAYLOAD_MAX + 1, 16'hFFFF)), 0);
         end else if (r < 82) begin
            repeat ($urandom_range(1, 6))
               feed(($urandom_range(0, 3) == 0) ? MAGIC_BYTE : 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4))
               read_payload(($urandom_range(0, 4) == 0 || last_len == 0) ?
                            10'($urandom) : 10'($urandom_range(0, last_len - 1)));
         end
         seg++;
         if (seg % 40 == 0) no_idle = ~no_idle;
         if (seg % 97 == 0) begin
            wait_drained();
            read_payload(10'd0);
         end
      end
      no_idle = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      fail_count = 0;
      items_sent = 0;
      cycles = 0;
      no_idle = 0;
      fill = 0;
      frame_total = 0;
      last_type = '0;
      last_seq = '0;
      last_len = '0;
      cnt_good = '0;
      cnt_version = '0;
      cnt_oversize = '0;
      cnt_crc = '0;
      cnt_resync = '0;
      version_sel = 8'd1;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_directed();
      test_version_setting();
      test_random_stream();

      @(negedge clock) req_tvalid <= 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results left over", pending_results.size(), 0);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
